[sv/sa_lru_pkg.sv]
`default_nettype none

package sa_lru_pkg;

  localparam int TAG_W        = 30;
  localparam int ADDR_W       = 32;
  localparam int OFFSET_W     = 4;
  localparam int WAY_OUT_W    = 3;
  localparam int SETS_DEFAULT = 64;
  localparam int WAYS_DEFAULT = 8;

  localparam logic [OFFSET_W-1:0] OFFSET_MIN   = 4'd2;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX   = 4'd8;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 4'd6;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_PROBE = 2'd2;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic                 filled;
    logic                 evicted_valid;
    logic [TAG_W-1:0]     evicted_block;
  } out_item_t;

endpackage

`default_nettype wire

[sv/set_assoc_lru_tag_store.sv]
// Tag store of a set-associative cache with true LRU replacement. Each item is
// a processor read, a processor write or a snoop probe at a byte address; the
// block address (address >> offset_bits, offset clamped to 2..8) is the tag and
// the block address modulo SETS picks the set. One result item per input item
// reports hit, way, whether a line was filled and any valid block evicted.
// After reset the block sweeps the set memory clear, one set per cycle, and
// takes no item meanwhile (cfg writes are taken at any time). An item is then
// handled in steps: one set read from the row memory, one way per cycle
// through a single tag comparator and rank tracker, and one write-back of
// tags, valid bits and LRU ranks (reads and writes only) once the output
// register is free. When SETS is not a power of two the set index is found
// first by a 4-bits-per-cycle remainder step. A finished result waits in an
// output register while the next item is accepted.
`default_nettype none

module set_assoc_lru_tag_store #(
  parameter int SETS = sa_lru_pkg::SETS_DEFAULT,
  parameter int WAYS = sa_lru_pkg::WAYS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [sa_lru_pkg::OFFSET_W-1:0]     cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire sa_lru_pkg::in_item_t                in_item,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output sa_lru_pkg::out_item_t                    out_item
);

  localparam int TAG_W  = sa_lru_pkg::TAG_W;
  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RANK_W = WAY_W;
  localparam int MOD_W  = SET_W + 4;
  localparam bit SET_POW2 = ((SETS & (SETS - 1)) == 0);
  localparam int MOD_STEPS = 8;

  localparam logic [SET_W-1:0]  SET_MASK  = SET_W'(SETS - 1);
  localparam logic [SET_W-1:0]  SET_LAST  = SET_W'(SETS - 1);
  localparam logic [WAY_W-1:0]  WAY_LAST  = WAY_W'(WAYS - 1);
  localparam logic [RANK_W:0]   RANK_NONE = (RANK_W + 1)'(WAYS);
  localparam logic [MOD_W-1:0]  SETS_X    = MOD_W'(SETS);
  localparam logic [2:0]        MOD_LAST  = 3'(MOD_STEPS - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_WRITE = 3'd5;

  typedef logic [WAYS-1:0]              valid_row_t;
  typedef logic [WAYS-1:0][TAG_W-1:0]   tag_row_t;
  typedef logic [WAYS-1:0][RANK_W-1:0]  rank_row_t;

  valid_row_t mem_valid [SETS];
  tag_row_t   mem_tag   [SETS];
  rank_row_t  mem_rank  [SETS];

  logic [2:0]                     state;
  logic [sa_lru_pkg::OFFSET_W-1:0] offset_bits;
  logic [SET_W-1:0]               clr_idx;
  logic [SET_W-1:0]               set_idx;
  logic [TAG_W-1:0]               block;
  logic                           is_proc;
  logic [31:0]                    mod_bits;
  logic [SET_W-1:0]               mod_rem;
  logic [SET_W-1:0]               mod_rem_next;
  logic [2:0]                     mod_cnt;
  logic [WAY_W-1:0]               scan_idx;
  logic                           hit_found;
  logic [WAY_W-1:0]               hit_way;
  logic                           have_inv;
  logic [WAY_W-1:0]               inv_way;
  logic [RANK_W-1:0]              best_rank;
  logic [WAY_W-1:0]               vic_way;

  valid_row_t rd_valid;
  tag_row_t   rd_tag;
  rank_row_t  rd_rank;

  valid_row_t new_valid;
  tag_row_t   new_tag;
  rank_row_t  new_rank;

  logic [sa_lru_pkg::OFFSET_W-1:0] sh;
  logic [sa_lru_pkg::ADDR_W-1:0]   shifted;
  logic [TAG_W-1:0]                in_block;
  logic [WAY_W-1:0]                tgt;
  logic [RANK_W:0]                 old_rank;
  logic                            wb_go;
  logic                            mem_we;
  logic [SET_W-1:0]                mem_addr;
  sa_lru_pkg::out_item_t           res;

  assign in_ready = (state == ST_IDLE);
  assign wb_go    = (state == ST_WRITE) && (!out_valid || out_ready);

  // offset clamp and block address
  always_comb begin
    if (offset_bits < sa_lru_pkg::OFFSET_MIN) begin
      sh = sa_lru_pkg::OFFSET_MIN;
    end else if (offset_bits > sa_lru_pkg::OFFSET_MAX) begin
      sh = sa_lru_pkg::OFFSET_MAX;
    end else begin
      sh = offset_bits;
    end
    shifted  = in_item.address >> sh;
    in_block = shifted[TAG_W-1:0];
  end

  // remainder step: four bits of the block address per cycle
  always_comb begin
    logic [MOD_W-1:0] t;
    t = {mod_rem, mod_bits[31:28]};
    for (int k = 3; k >= 0; k--) begin
      if (t >= (SETS_X << k)) begin
        t = t - (SETS_X << k);
      end
    end
    mod_rem_next = t[SET_W-1:0];
  end

  // write-back row: fill or touch the target way
  always_comb begin
    if (hit_found) begin
      tgt = hit_way;
    end else if (have_inv) begin
      tgt = inv_way;
    end else begin
      tgt = vic_way;
    end
    old_rank = rd_valid[tgt] ? {1'b0, rd_rank[tgt]} : RANK_NONE;
    for (int j = 0; j < WAYS; j++) begin
      if (WAY_W'(j) == tgt) begin
        new_valid[j] = 1'b1;
        new_tag[j]   = block;
        new_rank[j]  = '0;
      end else begin
        new_valid[j] = rd_valid[j];
        new_tag[j]   = rd_tag[j];
        if (rd_valid[j] && ({1'b0, rd_rank[j]} < old_rank)) begin
          new_rank[j] = rd_rank[j] + 1'b1;
        end else begin
          new_rank[j] = rd_rank[j];
        end
      end
    end
  end

  always_comb begin
    res.hit           = hit_found;
    res.filled        = !hit_found && is_proc;
    res.evicted_valid = !hit_found && is_proc && !have_inv;
    res.evicted_block = res.evicted_valid ? rd_tag[vic_way] : '0;
    if (hit_found) begin
      res.way = sa_lru_pkg::WAY_OUT_W'(hit_way);
    end else if (is_proc) begin
      res.way = sa_lru_pkg::WAY_OUT_W'(tgt);
    end else begin
      res.way = '0;
    end
  end

  assign mem_we   = (state == ST_CLEAR) || (wb_go && is_proc);
  assign mem_addr = (state == ST_CLEAR) ? clr_idx : set_idx;

  // set memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_valid[mem_addr] <= (state == ST_CLEAR) ? '0 : new_valid;
      mem_tag[mem_addr]   <= (state == ST_CLEAR) ? '0 : new_tag;
      mem_rank[mem_addr]  <= (state == ST_CLEAR) ? '0 : new_rank;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      rd_valid <= mem_valid[set_idx];
      rd_tag   <= mem_tag[set_idx];
      rd_rank  <= mem_rank[set_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= sa_lru_pkg::OFFSET_RESET;
    end else if (cfg_we) begin
      offset_bits <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
      scan_idx  <= '0;
      mod_cnt   <= '0;
      hit_found <= 1'b0;
      have_inv  <= 1'b0;
    end else begin
      if (wb_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == SET_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            block   <= in_block;
            is_proc <= (in_item.opcode == sa_lru_pkg::OP_READ) ||
                       (in_item.opcode == sa_lru_pkg::OP_WRITE);
            if (SET_POW2) begin
              set_idx <= in_block[SET_W-1:0] & SET_MASK;
              state   <= ST_READ;
            end else begin
              mod_bits <= {2'b00, in_block};
              mod_rem  <= '0;
              mod_cnt  <= '0;
              state    <= ST_MOD;
            end
          end
        end
        ST_MOD: begin
          mod_rem  <= mod_rem_next;
          mod_bits <= {mod_bits[27:0], 4'b0000};
          mod_cnt  <= mod_cnt + 1'b1;
          if (mod_cnt == MOD_LAST) begin
            set_idx <= mod_rem_next;
            state   <= ST_READ;
          end
        end
        ST_READ: begin
          scan_idx  <= '0;
          hit_found <= 1'b0;
          hit_way   <= '0;
          have_inv  <= 1'b0;
          inv_way   <= '0;
          best_rank <= '0;
          vic_way   <= '0;
          state     <= ST_SCAN;
        end
        ST_SCAN: begin
          if (rd_valid[scan_idx] && (rd_tag[scan_idx] == block) && !hit_found) begin
            hit_found <= 1'b1;
            hit_way   <= scan_idx;
          end
          if (!rd_valid[scan_idx] && !have_inv) begin
            have_inv <= 1'b1;
            inv_way  <= scan_idx;
          end
          if (rd_rank[scan_idx] >= best_rank) begin
            best_rank <= rd_rank[scan_idx];
            vic_way   <= scan_idx;
          end
          scan_idx <= scan_idx + 1'b1;
          if (scan_idx == WAY_LAST) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (wb_go) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wb_go) begin
      out_item <= res;
    end
  end

`ifndef SYNTH
  a_fill_not_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.hit && out_item.filled))
    else $error("fill reported together with hit");

  a_evict_needs_fill: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.evicted_valid) |-> out_item.filled)
    else $error("eviction without fill");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in progress");

  a_result_after_writeback: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_WRITE))
    else $error("result raised outside write-back");
`endif

endmodule

`default_nettype wire

[test/set_assoc_lru_tag_checker.sv]
`timescale 1ns / 1ps

module set_assoc_lru_tag_checker
  import sa_lru_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [OFFSET_W-1:0] cfg_wdata,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  wire in_item_t            in_item,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  wire out_item_t           out_item,
  output int                       errors,
  output int                       results_seen
);

  localparam int SETS = SETS_DEFAULT;
  localparam int WAYS = WAYS_DEFAULT;

  logic [OFFSET_W-1:0] offset_reg;
  logic                line_ok    [SETS*WAYS];
  logic [TAG_W-1:0]    stored_tag [SETS*WAYS];
  logic [2:0]          age        [SETS*WAYS];
  out_item_t           lookups_due[$];

  // make way w most recently used, aging the younger valid ways
  function automatic void promote(int base, int w);
    int old;
    old = line_ok[base+w] ? int'(age[base+w]) : WAYS;
    for (int j = 0; j < WAYS; j++) begin
      if (j != w && line_ok[base+j] && int'(age[base+j]) < old) begin
        age[base+j] = age[base+j] + 3'd1;
      end
    end
    age[base+w] = '0;
  endfunction

  function automatic out_item_t lookup(in_item_t it);
    out_item_t        r;
    int               sh;
    int               base;
    int               w;
    int               best;
    bit               found;
    bit               spare;
    bit               touches;
    logic [TAG_W-1:0] blk;
    r       = '0;
    found   = 1'b0;
    spare   = 1'b0;
    w       = 0;
    touches = (it.opcode == OP_READ) || (it.opcode == OP_WRITE);
    sh      = int'(offset_reg);
    if (sh < int'(OFFSET_MIN)) sh = int'(OFFSET_MIN);
    if (sh > int'(OFFSET_MAX)) sh = int'(OFFSET_MAX);
    blk  = TAG_W'(it.address >> sh);
    base = int'(blk % SETS) * WAYS;
    for (int j = 0; j < WAYS; j++) begin
      if (!found && line_ok[base+j] && stored_tag[base+j] == blk) begin
        found = 1'b1;
        w     = j;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      r.way = WAY_OUT_W'(w);
      if (touches) promote(base, w);
    end else if (touches) begin
      for (int j = 0; j < WAYS; j++) begin
        if (!spare && !line_ok[base+j]) begin
          spare = 1'b1;
          w     = j;
        end
      end
      if (!spare) begin
        // victim is the highest way with the greatest age
        best = 0;
        for (int j = 0; j < WAYS; j++) begin
          if (int'(age[base+j]) >= best) begin
            best = int'(age[base+j]);
            w    = j;
          end
        end
        r.evicted_valid = 1'b1;
        r.evicted_block = stored_tag[base+w];
      end
      promote(base, w);
      line_ok[base+w]    = 1'b1;
      stored_tag[base+w] = blk;
      r.filled           = 1'b1;
      r.way              = WAY_OUT_W'(w);
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    int        bad;
    if (rst) begin
      offset_reg = OFFSET_RESET;
      for (int i = 0; i < SETS*WAYS; i++) begin
        line_ok[i]    = 1'b0;
        stored_tag[i] = '0;
        age[i]        = '0;
      end
      lookups_due.delete();
    end else begin
      if (in_valid && in_ready) lookups_due.push_back(lookup(in_item));
      if (cfg_we) offset_reg = cfg_wdata;
      if (out_valid && out_ready) begin
        bad = 0;
        if (lookups_due.size() == 0) begin
          $error("result item with no lookup outstanding");
          bad = 1;
        end else begin
          want = lookups_due.pop_front();
          if (out_item.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, out_item.hit);
            bad++;
          end
          if (out_item.way !== want.way) begin
            $error("way: expected %0d, got %0d", want.way, out_item.way);
            bad++;
          end
          if (out_item.filled !== want.filled) begin
            $error("filled: expected %0d, got %0d", want.filled, out_item.filled);
            bad++;
          end
          if (out_item.evicted_valid !== want.evicted_valid) begin
            $error("evicted_valid: expected %0d, got %0d", want.evicted_valid,
                   out_item.evicted_valid);
            bad++;
          end
          if (out_item.evicted_block !== want.evicted_block) begin
            $error("evicted_block: expected %h, got %h", want.evicted_block,
                   out_item.evicted_block);
            bad++;
          end
        end
        errors       <= errors + bad;
        results_seen <= results_seen + 1;
      end
    end
  end

endmodule

[test/set_assoc_lru_tag_store_tb.sv]
`timescale 1ns / 1ps

module set_assoc_lru_tag_store_tb;
  import sa_lru_pkg::*;

  localparam logic [1:0] OP_SPARE    = 2'd3;
  localparam int         LIMIT       = 400000;
  localparam int         SETTLE      = WAYS_DEFAULT + 8;
  localparam int         HOLD_CYCLES = 300;
  localparam int         PHASE_ITEMS = 112;
  localparam int         POOL        = 20;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_we    = 1'b0;
  logic [OFFSET_W-1:0] cfg_wdata = '0;
  logic                in_valid  = 1'b0;
  in_item_t            in_item   = '0;
  logic                out_ready = 1'b0;
  logic                in_ready;
  logic                out_valid;
  out_item_t           out_item;

  int          errors;
  int          results_seen;
  int          sent      = 0;
  int          cycles    = 0;
  int          hold_req  = 0;
  int          hold_done = 0;
  int          cur_sh    = int'(OFFSET_RESET);
  bit          eager     = 1'b0;
  logic [31:0] pool [POOL];

  logic [OFFSET_W-1:0] offset_plan [9] = '{4'd6, 4'd2, 4'd8, 4'd0, 4'd15, 4'd9, 4'd1, 4'd5, 4'd6};

  set_assoc_lru_tag_store u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  set_assoc_lru_tag_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_item     (out_item),
    .errors       (errors),
    .results_seen (results_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: stretches of always ready, random and sparse ready, plus long holds
  initial begin : receiver
    int mode;
    int len;
    forever begin
      @(posedge clk);
      if (hold_req != hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = hold_req;
      end else begin
        mode = $urandom_range(0, 2);
        len  = $urandom_range(1, 40);
        repeat (len) begin
          case (mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  function automatic int clamp_shift(logic [OFFSET_W-1:0] v);
    if (v < OFFSET_MIN) return int'(OFFSET_MIN);
    if (v > OFFSET_MAX) return int'(OFFSET_MAX);
    return int'(v);
  endfunction

  function automatic in_item_t block_item(logic [1:0] op, logic [31:0] blk);
    in_item_t it;
    it.opcode  = op;
    it.address = blk << cur_sh;
    return it;
  endfunction

  // mostly blocks from a small pool crowding two sets, some wild addresses
  function automatic in_item_t next_access();
    in_item_t    it;
    logic [31:0] low;
    int          r;
    r = $urandom_range(0, 9);
    if (r < 4)      it.opcode = OP_READ;
    else if (r < 7) it.opcode = OP_WRITE;
    else if (r < 9) it.opcode = OP_PROBE;
    else            it.opcode = OP_SPARE;
    if ($urandom_range(0, 99) < 88) begin
      low        = (32'd1 << cur_sh) - 32'd1;
      it.address = (pool[$urandom_range(0, POOL-1)] & ~low) | ($urandom & low);
    end else begin
      it.address = $urandom;
    end
    return it;
  endfunction

  task automatic fill_pool();
    logic [5:0]  s0;
    logic [5:0]  s1;
    logic [31:0] a;
    s0 = 6'($urandom_range(0, 63));
    s1 = 6'($urandom_range(0, 63));
    for (int i = 0; i < POOL; i++) begin
      a             = $urandom;
      a[cur_sh +: 6] = (i % 2) ? s0 : s1;
      pool[i]       = a;
    end
  endtask

  task automatic send(input in_item_t it);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic drain();
    while (results_seen != sent) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_offset(input logic [OFFSET_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_sh = clamp_shift(v);
  endtask

  task automatic run_phase(input int n);
    int left;
    int burst;
    int gap;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 16);
      if (burst > left) burst = left;
      repeat (burst) begin
        send(next_access());
        left--;
      end
      gap = (eager || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (left == 0 || gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: address extremes, every opcode, fill and evict one set
    send(block_item(OP_READ, 32'd0));
    send(block_item(OP_PROBE, 32'd0));
    send(in_item_t'{opcode: OP_WRITE, address: 32'hFFFF_FFFF});
    send(block_item(OP_PROBE, 32'hFFFF_FFFF >> cur_sh));
    send(block_item(OP_SPARE, 32'd1));
    for (int k = 1; k <= 8; k++) begin
      send(block_item((k % 2) ? OP_READ : OP_WRITE, 32'(k * 64)));
    end
    send(block_item(OP_READ, 32'd192));
    send(block_item(OP_WRITE, 32'd576));
    send(block_item(OP_PROBE, 32'd64));
    send(block_item(OP_READ, 32'd0));
    send(block_item(OP_SPARE, 32'd192));
    send(in_item_t'{opcode: OP_READ, address: (32'd320 << cur_sh) | 32'h3F});
    in_valid <= 1'b0;
    drain();

    foreach (offset_plan[p]) begin
      set_offset(offset_plan[p]);
      fill_pool();
      eager = (p == 2);
      if (eager) hold_req++;
      run_phase(PHASE_ITEMS);
      drain();
    end

    if (errors == 0 && results_seen == sent) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
